>>> hw/rtl/prv_pkg.sv
package prv_pkg;

	localparam int NAME_BYTES    = 2048;
	localparam int SPRITE_BYTES  = 256;
	localparam int PATTERN_BYTES = 8192;
	localparam int PALETTE_BYTES = 32;

	localparam int SPRITE_AW  = $clog2(SPRITE_BYTES);
	localparam int PATTERN_AW = $clog2(PATTERN_BYTES);
	localparam int PALETTE_AW = $clog2(PALETTE_BYTES);
	localparam int FOLD_AW    = 11;

	localparam logic [9:0]  DOTS_PER_LINE = 10'd341;
	localparam logic [9:0]  LAST_DOT      = 10'd340;
	localparam logic [8:0]  VBLANK_LINE   = 9'd241;
	localparam logic [8:0]  LAST_LINE     = 9'd262;
	localparam logic [13:0] NAME_BASE     = 14'h2000;
	localparam logic [13:0] PAL_BASE      = 14'h3F00;
	localparam logic [13:0] STEP_ROW      = 14'd32;
	localparam logic [13:0] STEP_ONE      = 14'd1;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_LOAD  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_CTRL    = 3'd0,
		REG_MASK    = 3'd1,
		REG_STATUS  = 3'd2,
		REG_OAMADDR = 3'd3,
		REG_OAMDATA = 3'd4,
		REG_SCROLL  = 3'd5,
		REG_ADDR    = 3'd6,
		REG_DATA    = 3'd7
	} reg_t;

	// where the read byte of an item comes from once the memories answer
	typedef enum logic [2:0] {
		SRC_ZERO     = 3'd0,
		SRC_REG      = 3'd1,
		SRC_SPRITE   = 3'd2,
		SRC_PALETTE  = 3'd3,
		SRC_BUF_PAT  = 3'd4,
		SRC_BUF_NAME = 3'd5
	} src_t;

	typedef struct packed {
		src_t       src;
		logic [7:0] reg_val;
		logic       frame_done;
		logic       nmi;
	} issue_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       frame_done;
		logic       nmi_pending;
	} result_t;

	// nametable fold: 0 horizontal, 1 vertical mirroring
	function automatic logic [FOLD_AW-1:0] fold_name(input logic [13:0] addr,
			input logic mirror);
		logic [FOLD_AW-1:0] idx;
		if (mirror) begin
			idx = addr[10:0];
		end else begin
			idx = {addr[11], addr[9:0]};
		end
		return idx;
	endfunction

	// palette mirrors of the backdrop entries
	function automatic logic [PALETTE_AW-1:0] fold_pal(input logic [13:0] addr);
		logic [PALETTE_AW-1:0] idx;
		idx = addr[PALETTE_AW-1:0];
		if (idx[4] && (idx[1:0] == 2'b00)) begin
			idx[4] = 1'b0;
		end
		return idx;
	endfunction

endpackage

>>> hw/rtl/prv_if.sv
interface prv_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [2:0]  reg_sel;
	logic [7:0]  write_byte;
	logic [8:0]  dot_count;
	logic [12:0] load_addr;

	modport source (output valid, output mode, output reg_sel, output write_byte,
		output dot_count, output load_addr, input ready);
	modport sink (input valid, input mode, input reg_sel, input write_byte,
		input dot_count, input load_addr, output ready);
endinterface

interface prv_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic       frame_done;
	logic       nmi_pending;

	modport source (output valid, output read_byte, output frame_done,
		output nmi_pending, input ready);
	modport sink (input valid, input read_byte, input frame_done,
		input nmi_pending, output ready);
endinterface

>>> hw/rtl/prv_ram.sv
module prv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/prv_front.sv
module prv_front #(
	parameter int NAME_BYTES = prv_pkg::NAME_BYTES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic                                 cfg_wr_data,
	input  logic                                 fire,
	input  logic [1:0]                           mode,
	input  logic [2:0]                           reg_sel,
	input  logic [7:0]                           write_byte,
	input  logic [8:0]                           dot_count,
	input  logic [12:0]                          load_addr,
	output logic                                 busy,
	output prv_pkg::issue_t                      issue,
	output logic                                 spr_we,
	output logic [prv_pkg::SPRITE_AW-1:0]        spr_waddr,
	output logic [7:0]                           spr_wdata,
	output logic [prv_pkg::SPRITE_AW-1:0]        spr_raddr,
	output logic                                 name_we,
	output logic [$clog2(NAME_BYTES)-1:0]        name_waddr,
	output logic [7:0]                           name_wdata,
	output logic [$clog2(NAME_BYTES)-1:0]        name_raddr,
	output logic                                 pal_we,
	output logic [prv_pkg::PALETTE_AW-1:0]       pal_waddr,
	output logic [7:0]                           pal_wdata,
	output logic [prv_pkg::PALETTE_AW-1:0]       pal_raddr,
	output logic                                 pat_we,
	output logic [prv_pkg::PATTERN_AW-1:0]       pat_waddr,
	output logic [7:0]                           pat_wdata,
	output logic [prv_pkg::PATTERN_AW-1:0]       pat_raddr
);

	localparam int NAW = $clog2(NAME_BYTES);
	localparam logic [NAW-1:0] CLR_LAST = NAW'(NAME_BYTES - 1);

	logic        mirror_q;
	logic [7:0]  ctrl_q, mask_q, status_q, spr_q;
	logic [13:0] addr_q;
	logic        hbn_q, nmi_q;
	logic [8:0]  dot_q, line_q;
	logic [NAW-1:0] clr_q;
	logic        busy_q;

	logic [7:0]  ctrl_n, mask_n, status_n, spr_n;
	logic [13:0] addr_n, addr_step;
	logic        hbn_n, nmi_n;
	logic [8:0]  dot_n, line_n, line_inc;
	logic [9:0]  dot_sum, dot_rem;
	logic        in_name, in_pal;
	logic        item_spr_we, item_name_we, item_pal_we;
	logic [NAW-1:0] name_idx;

	assign busy      = busy_q;
	assign addr_step = addr_q + (ctrl_q[2] ? prv_pkg::STEP_ROW : prv_pkg::STEP_ONE);
	assign in_name   = (addr_q >= prv_pkg::NAME_BASE) && (addr_q < prv_pkg::PAL_BASE);
	assign in_pal    = addr_q >= prv_pkg::PAL_BASE;
	assign name_idx  = NAW'(prv_pkg::fold_name(addr_q, mirror_q));
	assign dot_sum   = {1'b0, dot_q} + {1'b0, dot_count};
	assign dot_rem   = dot_sum - prv_pkg::DOTS_PER_LINE;
	assign line_inc  = line_q + 9'd1;

	always_comb begin
		ctrl_n       = ctrl_q;
		mask_n       = mask_q;
		status_n     = status_q;
		spr_n        = spr_q;
		addr_n       = addr_q;
		hbn_n        = hbn_q;
		nmi_n        = nmi_q;
		dot_n        = dot_q;
		line_n       = line_q;
		item_spr_we  = 1'b0;
		item_name_we = 1'b0;
		item_pal_we  = 1'b0;
		issue        = '{src: prv_pkg::SRC_ZERO, reg_val: 8'd0, frame_done: 1'b0,
			nmi: 1'b0};
		unique case (prv_pkg::mode_t'(mode))
			prv_pkg::MODE_WRITE: begin
				unique case (prv_pkg::reg_t'(reg_sel))
					prv_pkg::REG_CTRL: begin
						ctrl_n = write_byte;
						if (!ctrl_q[7] && write_byte[7] && status_q[7]) begin
							nmi_n = 1'b1;
						end
					end
					prv_pkg::REG_MASK:    mask_n = write_byte;
					prv_pkg::REG_OAMADDR: spr_n = write_byte;
					prv_pkg::REG_OAMDATA: begin
						item_spr_we = 1'b1;
						spr_n       = spr_q + 8'd1;
					end
					prv_pkg::REG_ADDR: begin
						if (hbn_q) begin
							addr_n = {write_byte[5:0], addr_q[7:0]};
						end else begin
							addr_n = {addr_q[13:8], write_byte};
						end
						hbn_n = !hbn_q;
					end
					prv_pkg::REG_DATA: begin
						item_name_we = in_name;
						item_pal_we  = in_pal;
						addr_n       = addr_step;
					end
					default: begin
					end
				endcase
			end
			prv_pkg::MODE_READ: begin
				unique case (prv_pkg::reg_t'(reg_sel))
					prv_pkg::REG_STATUS: begin
						issue.src     = prv_pkg::SRC_REG;
						issue.reg_val = status_q;
						status_n      = {1'b0, status_q[6:0]};
						hbn_n         = 1'b1;
					end
					prv_pkg::REG_OAMDATA: issue.src = prv_pkg::SRC_SPRITE;
					prv_pkg::REG_DATA: begin
						addr_n = addr_step;
						if (in_pal) begin
							issue.src = prv_pkg::SRC_PALETTE;
						end else if (in_name) begin
							issue.src = prv_pkg::SRC_BUF_NAME;
						end else begin
							issue.src = prv_pkg::SRC_BUF_PAT;
						end
					end
					default: begin
					end
				endcase
			end
			prv_pkg::MODE_TICK: begin
				if (dot_sum >= prv_pkg::DOTS_PER_LINE) begin
					dot_n = (dot_rem > prv_pkg::LAST_DOT) ? prv_pkg::LAST_DOT[8:0]
						: dot_rem[8:0];
					line_n = line_inc;
					if (line_inc == prv_pkg::VBLANK_LINE) begin
						status_n = {1'b1, 1'b0, status_q[5:0]};
						if (ctrl_q[7]) begin
							nmi_n = 1'b1;
						end
					end
					if (line_inc >= prv_pkg::LAST_LINE) begin
						line_n           = 9'd0;
						nmi_n            = 1'b0;
						status_n         = {2'b00, status_q[5:0]};
						issue.frame_done = 1'b1;
					end
				end else begin
					dot_n = dot_sum[8:0];
				end
			end
			prv_pkg::MODE_LOAD: begin
			end
			default: begin
			end
		endcase
		issue.nmi = nmi_n;
	end

	// memory ports: clearing sweep owns the sprite, nametable and palette write sides after reset
	always_comb begin
		spr_raddr  = spr_q;
		name_raddr = name_idx;
		pal_raddr  = prv_pkg::fold_pal(addr_q);
		pat_raddr  = addr_q[prv_pkg::PATTERN_AW-1:0];
		pat_we     = fire && (prv_pkg::mode_t'(mode) == prv_pkg::MODE_LOAD);
		pat_waddr  = load_addr;
		pat_wdata  = write_byte;
		if (busy_q) begin
			spr_we     = 1'b1;
			spr_waddr  = clr_q[prv_pkg::SPRITE_AW-1:0];
			spr_wdata  = 8'd0;
			name_we    = 1'b1;
			name_waddr = clr_q;
			name_wdata = 8'd0;
			pal_we     = 1'b1;
			pal_waddr  = clr_q[prv_pkg::PALETTE_AW-1:0];
			pal_wdata  = 8'd0;
		end else begin
			spr_we     = fire && item_spr_we;
			spr_waddr  = spr_q;
			spr_wdata  = write_byte;
			name_we    = fire && item_name_we;
			name_waddr = name_idx;
			name_wdata = write_byte;
			pal_we     = fire && item_pal_we;
			pal_waddr  = prv_pkg::fold_pal(addr_q);
			pal_wdata  = write_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
			ctrl_q   <= 8'd0;
			mask_q   <= 8'd0;
			status_q <= 8'd0;
			spr_q    <= 8'd0;
			addr_q   <= 14'd0;
			hbn_q    <= 1'b1;
			nmi_q    <= 1'b0;
			dot_q    <= 9'd0;
			line_q   <= 9'd0;
			clr_q    <= '0;
			busy_q   <= 1'b1;
		end else begin
			if (cfg_wr_en) begin
				mirror_q <= cfg_wr_data;
			end
			if (busy_q) begin
				clr_q <= clr_q + NAW'(1);
				if (clr_q == CLR_LAST) begin
					busy_q <= 1'b0;
				end
			end
			if (fire) begin
				ctrl_q   <= ctrl_n;
				mask_q   <= mask_n;
				status_q <= status_n;
				spr_q    <= spr_n;
				addr_q   <= addr_n;
				hbn_q    <= hbn_n;
				nmi_q    <= nmi_n;
				dot_q    <= dot_n;
				line_q   <= line_n;
			end
		end
	end

endmodule

>>> hw/rtl/prv_back.sv
module prv_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  prv_pkg::issue_t   issue,
	input  logic [7:0]        spr_rdata,
	input  logic [7:0]        name_rdata,
	input  logic [7:0]        pal_rdata,
	input  logic [7:0]        pat_rdata,
	output logic              room,
	prv_res_if.source         res
);

	logic              valid_s1;
	prv_pkg::issue_t   issue_s1;
	logic [7:0]        buf_q;
	prv_pkg::result_t  fifo_q [2];
	logic              wr_q, rd_q;
	logic [1:0]        cnt_q;
	logic              pop;
	logic [2:0]        level;
	prv_pkg::result_t  result;

	assign pop   = res.valid && res.ready;
	assign level = ({1'b0, cnt_q} + {2'b00, valid_s1}) - {2'b00, pop};
	assign room  = level <= 3'd1;

	always_comb begin
		case (issue_s1.src) inside
			prv_pkg::SRC_REG:                          result.read_byte = issue_s1.reg_val;
			prv_pkg::SRC_SPRITE:                       result.read_byte = spr_rdata;
			prv_pkg::SRC_PALETTE:                      result.read_byte = pal_rdata;
			prv_pkg::SRC_BUF_PAT, prv_pkg::SRC_BUF_NAME: result.read_byte = buf_q;
			default:                                   result.read_byte = 8'd0;
		endcase
		result.frame_done  = issue_s1.frame_done;
		result.nmi_pending = issue_s1.nmi;
	end

	assign res.valid       = cnt_q != 2'd0;
	assign res.read_byte   = fifo_q[rd_q].read_byte;
	assign res.frame_done  = fifo_q[rd_q].frame_done;
	assign res.nmi_pending = fifo_q[rd_q].nmi_pending;

	always_ff @(posedge clk) begin
		if (fire) begin
			issue_s1 <= issue;
		end
		if (valid_s1) begin
			fifo_q[wr_q] <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			buf_q    <= 8'd0;
			wr_q     <= 1'b0;
			rd_q     <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			valid_s1 <= fire;
			if (valid_s1 && (issue_s1.src == prv_pkg::SRC_BUF_PAT)) begin
				buf_q <= pat_rdata;
			end else if (valid_s1 && (issue_s1.src == prv_pkg::SRC_BUF_NAME)) begin
				buf_q <= name_rdata;
			end
			if (valid_s1) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, valid_s1} - {1'b0, pop};
		end
	end

endmodule

>>> hw/rtl/ppu_register_port_vblank.sv
// picture-unit register port: each cmd item is a register write, a register read, a dot
// tick or a pattern memory load, and gives exactly one res item (read byte, end-of-frame
// flag, nmi level). one item is taken every clock while cmd ready is high; the sprite,
// nametable, palette and pattern memories answer in the cycle after the address is issued,
// and the result then goes into a two-entry result queue, so res valid rises once the
// item has passed the issue register and been written into the queue. cmd ready looks
// at res ready in the same cycle: the queue catches the item still in flight when res
// stalls, so a steady stream pauses on cmd for each cycle that res is stalled with a
// result waiting. after reset the block sweeps the nametable, sprite and palette memories
// to zero, one entry per cycle, through all NAME_BYTES nametable entries (2048 by default);
// cmd ready stays low during the sweep while mirror_mode writes are taken as usual. pattern
// memory is not cleared and must be loaded before the data port reads it.
module ppu_register_port_vblank #(
	parameter int NAME_BYTES = prv_pkg::NAME_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	prv_cmd_if.sink     cmd,
	prv_res_if.source   res
);

	localparam int NAW = $clog2(NAME_BYTES);

	logic              busy, room, fire;
	prv_pkg::issue_t   issue;

	// per-memory write and read ports
	logic                              spr_we, name_we, pal_we, pat_we;
	logic [prv_pkg::SPRITE_AW-1:0]     spr_waddr, spr_raddr;
	logic [NAW-1:0]                    name_waddr, name_raddr;
	logic [prv_pkg::PALETTE_AW-1:0]    pal_waddr, pal_raddr;
	logic [prv_pkg::PATTERN_AW-1:0]    pat_waddr, pat_raddr;
	logic [7:0]                        spr_wdata, name_wdata, pal_wdata, pat_wdata;
	logic [7:0]                        spr_rdata, name_rdata, pal_rdata, pat_rdata;

	// item taken whenever the result queue has a free slot and the sweep is over
	assign cmd.ready = room && !busy;
	assign fire      = cmd.valid && cmd.ready;

	// register state, address folding and memory requests
	prv_front #(
		.NAME_BYTES (NAME_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.mode        (cmd.mode),
		.reg_sel     (cmd.reg_sel),
		.write_byte  (cmd.write_byte),
		.dot_count   (cmd.dot_count),
		.load_addr   (cmd.load_addr),
		.busy        (busy),
		.issue       (issue),
		.spr_we      (spr_we),
		.spr_waddr   (spr_waddr),
		.spr_wdata   (spr_wdata),
		.spr_raddr   (spr_raddr),
		.name_we     (name_we),
		.name_waddr  (name_waddr),
		.name_wdata  (name_wdata),
		.name_raddr  (name_raddr),
		.pal_we      (pal_we),
		.pal_waddr   (pal_waddr),
		.pal_wdata   (pal_wdata),
		.pal_raddr   (pal_raddr),
		.pat_we      (pat_we),
		.pat_waddr   (pat_waddr),
		.pat_wdata   (pat_wdata),
		.pat_raddr   (pat_raddr)
	);

	// sprite attribute memory
	prv_ram #(
		.WIDTH (8),
		.DEPTH (prv_pkg::SPRITE_BYTES)
	) u_spr_ram (
		.clk   (clk),
		.we    (spr_we),
		.waddr (spr_waddr),
		.wdata (spr_wdata),
		.raddr (spr_raddr),
		.rdata (spr_rdata)
	);

	// nametable memory, addressed after mirroring
	prv_ram #(
		.WIDTH (8),
		.DEPTH (NAME_BYTES)
	) u_name_ram (
		.clk   (clk),
		.we    (name_we),
		.waddr (name_waddr),
		.wdata (name_wdata),
		.raddr (name_raddr),
		.rdata (name_rdata)
	);

	// palette memory, backdrop mirrors folded
	prv_ram #(
		.WIDTH (8),
		.DEPTH (prv_pkg::PALETTE_BYTES)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	// pattern memory, filled by load items only
	prv_ram #(
		.WIDTH (8),
		.DEPTH (prv_pkg::PATTERN_BYTES)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (pat_wdata),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	// read data select, data-port read buffer and result queue
	prv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.issue      (issue),
		.spr_rdata  (spr_rdata),
		.name_rdata (name_rdata),
		.pal_rdata  (pal_rdata),
		.pat_rdata  (pat_rdata),
		.room       (room),
		.res        (res)
	);

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import prv_pkg::*;

	// picture timing, in dots and lines
	localparam int LINE_DOTS   = 341;
	localparam int VBL_LINE    = 241;
	localparam int FRAME_LINES = 262;

	// video address map
	localparam logic [13:0] NT_LO  = 14'h2000;
	localparam logic [13:0] PAL_LO = 14'h3F00;

	// one bus item as it goes out on the cmd channel
	typedef struct {
		mode_t       op;
		reg_t        reg_sel;
		logic [7:0]  data;
		logic [8:0]  dots;
		logic [12:0] load_addr;
	} cmd_item_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	prv_cmd_if cmd_bus ();
	prv_res_if res_bus ();

	ppu_register_port_vblank dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_bus),
		.res         (res_bus)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// shadow of the register port: counters, registers, latch, memories
	// ------------------------------------------------------------------
	logic        mirror_vert;
	logic [8:0]  dot_ctr;
	logic [8:0]  line_ctr;
	logic [7:0]  ctrl_q;
	logic [7:0]  mask_q;
	logic [7:0]  status_q;
	logic [13:0] vaddr;
	logic        hi_next;
	logic [7:0]  rbuf;
	logic        nmi_q;
	logic [7:0]  oam_ptr;
	logic [7:0]  oam_mem [SPRITE_BYTES];
	logic [7:0]  nt_mem  [NAME_BYTES];
	logic [7:0]  pal_mem [PALETTE_BYTES];
	logic [7:0]  pat_mem [PATTERN_BYTES];
	bit          pat_loaded [PATTERN_BYTES];

	// items waiting for the driver, and the results they must produce
	cmd_item_t pending_items[$];
	result_t   expected_results[$];

	int queued_count;
	int accepted_count;
	int results_checked;
	int reads_checked;
	int frames_seen;
	int nmi_results;
	int mismatch_count;

	// handshake bookkeeping
	logic cmd_taken;
	int   cmd_gap;
	int   res_stall;
	bit   no_idle;

	// nametable index after the 0x2fff fold and the mirroring fold
	function automatic logic [10:0] nt_index(logic [13:0] a);
		int idx;
		idx = a[11:0];
		if (mirror_vert) begin
			if (idx >= 'h800) idx -= 'h800;
		end else if (idx >= 'hC00) begin
			idx -= 'h800;
		end else if (idx >= 'h400) begin
			idx -= 'h400;
		end
		return idx[10:0];
	endfunction

	// palette index; sprite backdrop entries land on the background ones
	function automatic logic [4:0] pal_index(logic [13:0] a);
		logic [4:0] idx;
		idx = a[4:0];
		if ((idx & 5'h13) == 5'h10) idx &= 5'h0F;
		return idx;
	endfunction

	// applies one item to the shadow state and returns the result it gives
	function automatic result_t advance_port(cmd_item_t it);
		result_t     r;
		int          sum;
		logic [13:0] a;
		r = '0;
		case (it.op)
		MODE_WRITE: begin
			case (it.reg_sel)
			REG_CTRL: begin
				// nmi enable rising while vblank is up fires at once
				if (!ctrl_q[7] && it.data[7] && status_q[7]) nmi_q = 1'b1;
				ctrl_q = it.data;
			end
			REG_MASK:    mask_q = it.data;
			REG_OAMADDR: oam_ptr = it.data;
			REG_OAMDATA: begin
				oam_mem[oam_ptr] = it.data;
				oam_ptr++;
			end
			REG_ADDR: begin
				if (hi_next) vaddr = {it.data[5:0], vaddr[7:0]};
				else vaddr = {vaddr[13:8], it.data};
				hi_next = !hi_next;
			end
			REG_DATA: begin
				// pattern space is read-only from the data port
				if (vaddr >= PAL_LO) pal_mem[pal_index(vaddr)] = it.data;
				else if (vaddr >= NT_LO) nt_mem[nt_index(vaddr)] = it.data;
				vaddr += ctrl_q[2] ? 14'd32 : 14'd1;
			end
			default: ;
			endcase
		end
		MODE_READ: begin
			case (it.reg_sel)
			REG_STATUS: begin
				r.read_byte = status_q;
				status_q[7] = 1'b0;
				hi_next = 1'b1;
			end
			REG_OAMDATA: r.read_byte = oam_mem[oam_ptr];
			REG_DATA: begin
				a = vaddr;
				vaddr += ctrl_q[2] ? 14'd32 : 14'd1;
				if (a >= PAL_LO) begin
					r.read_byte = pal_mem[pal_index(a)];
				end else begin
					r.read_byte = rbuf;
					rbuf = (a >= NT_LO) ? nt_mem[nt_index(a)] : pat_mem[a[12:0]];
				end
			end
			default: r.read_byte = '0;
			endcase
		end
		MODE_TICK: begin
			// at most one line per tick, leftover dots saturate
			sum = dot_ctr + it.dots;
			if (sum >= LINE_DOTS) begin
				sum -= LINE_DOTS;
				if (sum > LINE_DOTS - 1) sum = LINE_DOTS - 1;
				line_ctr++;
				if (line_ctr == VBL_LINE) begin
					status_q[7] = 1'b1;
					status_q[6] = 1'b0;
					if (ctrl_q[7]) nmi_q = 1'b1;
				end
				if (line_ctr >= FRAME_LINES) begin
					line_ctr = '0;
					nmi_q = 1'b0;
					status_q[7:6] = 2'b00;
					r.frame_done = 1'b1;
				end
			end
			dot_ctr = sum[8:0];
		end
		default: begin
			pat_mem[it.load_addr] = it.data;
			pat_loaded[it.load_addr] = 1'b1;
		end
		endcase
		r.nmi_pending = nmi_q;
		return r;
	endfunction

	// queue one item and its expected result; a negative dots or load
	// address means random. a data-port read of pattern space that would
	// hit an unloaded byte gets a load of that byte queued ahead of it
	task automatic queue_op(mode_t op, reg_t sel, logic [7:0] data, int dots = -1,
			int load_addr = -1);
		cmd_item_t it;
		if (op == MODE_READ && sel == REG_DATA && vaddr < NT_LO && !pat_loaded[vaddr[12:0]])
			queue_op(MODE_LOAD, reg_t'($urandom_range(0, 7)), 8'($urandom), -1,
				int'(vaddr[12:0]));
		it.op = op;
		it.reg_sel = sel;
		it.data = data;
		it.dots = (dots < 0) ? 9'($urandom_range(0, LINE_DOTS)) : 9'(dots);
		it.load_addr = (load_addr < 0) ? 13'($urandom) : 13'(load_addr);
		pending_items.push_back(it);
		expected_results.push_back(advance_port(it));
		queued_count++;
	endtask

	// mirroring changes only while nothing is in flight
	task automatic set_mirror(logic v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mirror_vert = v;
	endtask

	// wait for every queued item to come back, plus the pipeline depth
	task automatic drain();
		while (pending_items.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// random traffic: mostly well-formed register sequences and line ticks
	task automatic run_phase(int n_items);
		int start;
		int pick;
		int hi;
		int k;
		start = queued_count;
		while (queued_count - start < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// address setup then a burst of data-port accesses
				if (!hi_next || $urandom_range(0, 3) == 0)
					queue_op(MODE_READ, REG_STATUS, 8'($urandom));
				case ($urandom_range(0, 3))
				0: hi = $urandom_range('h00, 'h1F);
				1: hi = $urandom_range('h20, 'h3E);
				2: hi = 'h3F;
				default: hi = $urandom_range(0, 255);
				endcase
				queue_op(MODE_WRITE, REG_ADDR, 8'(hi));
				queue_op(MODE_WRITE, REG_ADDR, 8'($urandom));
				k = $urandom_range(1, 6);
				repeat (k)
					queue_op($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, REG_DATA,
						8'($urandom));
			end else if (pick < 25) begin
				queue_op(MODE_WRITE, REG_CTRL, 8'($urandom));
			end else if (pick < 29) begin
				queue_op(MODE_WRITE, REG_MASK, 8'($urandom));
			end else if (pick < 38) begin
				// sprite memory: pointer, some stores, a look back
				queue_op(MODE_WRITE, REG_OAMADDR, 8'($urandom));
				k = $urandom_range(0, 4);
				repeat (k) queue_op(MODE_WRITE, REG_OAMDATA, 8'($urandom));
				if ($urandom_range(0, 1)) queue_op(MODE_WRITE, REG_OAMADDR, 8'($urandom));
				queue_op(MODE_READ, REG_OAMDATA, 8'($urandom));
			end else if (pick < 44) begin
				queue_op(MODE_READ, REG_STATUS, 8'($urandom));
			end else if (pick < 84) begin
				// mostly near a whole line so frames go by
				if ($urandom_range(0, 4) != 0)
					queue_op(MODE_TICK, reg_t'($urandom_range(0, 7)), 8'($urandom),
						$urandom_range(300, LINE_DOTS));
				else
					queue_op(MODE_TICK, reg_t'($urandom_range(0, 7)), 8'($urandom),
						$urandom_range(0, LINE_DOTS));
			end else if (pick < 90) begin
				queue_op(MODE_LOAD, reg_t'($urandom_range(0, 7)), 8'($urandom));
			end else begin
				// noise: any kind, any register
				queue_op(mode_t'($urandom_range(0, 3)), reg_t'($urandom_range(0, 7)),
					8'($urandom));
			end
		end
	endtask

	task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("ERROR result %0d: %s got %h want %h", results_checked, what, got, want);
		mismatch_count++;
	endtask

	// gap after an item or a ready pulse: mostly none or short, a few long
	function automatic int idle_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// cmd driver: changes on the falling edge, holds until taken
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cmd_taken <= arst_n && cmd_bus.valid && cmd_bus.ready;
		if (arst_n && cmd_bus.valid && cmd_bus.ready) accepted_count++;
	end

	always @(negedge clk) begin : cmd_driver
		cmd_item_t it;
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
		end else if (!cmd_bus.valid || cmd_taken) begin
			if (cmd_gap > 0 || pending_items.size() == 0) begin
				cmd_bus.valid <= 1'b0;
				if (cmd_gap > 0) cmd_gap--;
			end else begin
				it = pending_items.pop_front();
				cmd_bus.valid <= 1'b1;
				cmd_bus.mode <= it.op;
				cmd_bus.reg_sel <= it.reg_sel;
				cmd_bus.write_byte <= it.data;
				cmd_bus.dot_count <= it.dots;
				cmd_bus.load_addr <= it.load_addr;
				cmd_gap = idle_gap();
			end
		end
	end

	// res ready: random stalls, with stretches of none
	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0) no_idle = !no_idle;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else if (res_stall > 0) begin
			res_bus.ready <= 1'b0;
			res_stall--;
		end else begin
			res_bus.ready <= 1'b1;
			res_stall = idle_gap();
		end
	end

	// ------------------------------------------------------------------
	// res monitor: every taken result against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin : res_monitor
		result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_results.size() == 0) begin
				note_mismatch("result with nothing expected, read_byte", res_bus.read_byte,
					8'h00);
			end else begin
				want = expected_results.pop_front();
				if (res_bus.read_byte !== want.read_byte)
					note_mismatch("read_byte", res_bus.read_byte, want.read_byte);
				if (res_bus.frame_done !== want.frame_done)
					note_mismatch("frame_done", 8'(res_bus.frame_done), 8'(want.frame_done));
				if (res_bus.nmi_pending !== want.nmi_pending)
					note_mismatch("nmi_pending", 8'(res_bus.nmi_pending),
						8'(want.nmi_pending));
				if (want.read_byte != 0) reads_checked++;
				if (want.frame_done) frames_seen++;
				if (want.nmi_pending) nmi_results++;
			end
			results_checked++;
		end
	end

	// ------------------------------------------------------------------
	// stimulus: reset, directed corners, then four random phases that
	// alternate the mirroring mode
	// ------------------------------------------------------------------
	initial begin
		cmd_bus.valid = 1'b0;
		cmd_bus.mode = '0;
		cmd_bus.reg_sel = '0;
		cmd_bus.write_byte = '0;
		cmd_bus.dot_count = '0;
		cmd_bus.load_addr = '0;
		res_bus.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		cmd_taken = 1'b0;
		cmd_gap = 0;
		res_stall = 0;
		no_idle = 1'b0;

		// shadow state at reset
		mirror_vert = 1'b0;
		dot_ctr = '0;
		line_ctr = '0;
		ctrl_q = '0;
		mask_q = '0;
		status_q = '0;
		vaddr = '0;
		hi_next = 1'b1;
		rbuf = '0;
		nmi_q = 1'b0;
		oam_ptr = '0;
		foreach (oam_mem[i]) oam_mem[i] = '0;
		foreach (nt_mem[i]) nt_mem[i] = '0;
		foreach (pal_mem[i]) pal_mem[i] = '0;
		foreach (pat_loaded[i]) pat_loaded[i] = 1'b0;

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// horizontal mirroring to start; taken even during the clearing sweep
		set_mirror(1'b0);

		// pattern corners
		queue_op(MODE_LOAD, REG_CTRL, 8'hFF, LINE_DOTS, 'h1FFF);
		queue_op(MODE_LOAD, REG_DATA, 8'h00, 0, 'h0000);
		// status straight out of reset
		queue_op(MODE_READ, REG_STATUS, 8'h00);
		// buffered pattern reads: first answers the stale buffer
		queue_op(MODE_WRITE, REG_ADDR, 8'h00);
		queue_op(MODE_WRITE, REG_ADDR, 8'h00);
		queue_op(MODE_READ, REG_DATA, 8'h00);
		queue_op(MODE_READ, REG_DATA, 8'h00);
		// address wider than 14 bits, top palette entry
		queue_op(MODE_WRITE, REG_ADDR, 8'hFF);
		queue_op(MODE_WRITE, REG_ADDR, 8'hFF);
		queue_op(MODE_WRITE, REG_DATA, 8'hAA);
		// step of 32, backdrop alias, direct palette read
		queue_op(MODE_WRITE, REG_CTRL, 8'h04);
		queue_op(MODE_WRITE, REG_ADDR, 8'h3F);
		queue_op(MODE_WRITE, REG_ADDR, 8'h10);
		queue_op(MODE_WRITE, REG_DATA, 8'h5A);
		queue_op(MODE_READ, REG_DATA, 8'h00);
		// nametable write in the fourth table
		queue_op(MODE_WRITE, REG_CTRL, 8'h00);
		queue_op(MODE_WRITE, REG_ADDR, 8'h2C);
		queue_op(MODE_WRITE, REG_ADDR, 8'h00);
		queue_op(MODE_WRITE, REG_DATA, 8'h77);
		// sprite pointer wrap, then read without increment
		queue_op(MODE_WRITE, REG_OAMADDR, 8'hFF);
		queue_op(MODE_WRITE, REG_OAMDATA, 8'h3C);
		queue_op(MODE_READ, REG_OAMDATA, 8'h00);
		// ignored writes and reads that answer zero
		queue_op(MODE_WRITE, REG_STATUS, 8'hFF);
		queue_op(MODE_WRITE, REG_SCROLL, 8'h12);
		queue_op(MODE_READ, REG_SCROLL, 8'h00);
		// whole-line tick and an empty one
		queue_op(MODE_TICK, REG_MASK, 8'h00, LINE_DOTS);
		queue_op(MODE_TICK, REG_MASK, 8'h00, 0);

		run_phase(430);
		drain();
		set_mirror(1'b1);
		run_phase(430);
		drain();
		set_mirror(1'b0);
		run_phase(430);
		drain();
		set_mirror(1'b1);
		run_phase(430);
		drain();

		$display("run covered %0d items in both mirroring modes: %0d nonzero reads,",
			accepted_count, reads_checked);
		$display("  %0d frames completed, %0d results with nmi pending", frames_seen,
			nmi_results);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#(64'd20_000_000);
		$display("timeout with %0d results still expected", expected_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
